// ===== hdl/gshare_branch_predictor_defines.svh =====
// ---------------------------------------------------------------------------
// gshare branch predictor assertion macros
// concurrent checks that compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef GSHARE_BRANCH_PREDICTOR_DEFINES_SVH
`define GSHARE_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
// check that is skipped while reset is asserted
`define GBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that also holds during reset
`define GBP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBP_ASSERT(lbl, prop, msg)
`define GBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/gbp_pkg.sv =====
// ---------------------------------------------------------------------------
// gbp_pkg
// shared constants, field widths and counter update for the gshare predictor
// ---------------------------------------------------------------------------
package gbp_pkg;

	// default table geometry
	localparam int COUNTER_INDEX_BITS_DEF = 12;
	localparam int TARGET_INDEX_BITS_DEF  = 10;
	localparam int HISTORY_BITS_DEF       = 21;

	// fixed field widths
	localparam int PC_W       = 32;
	localparam int IDX_FIELD_W = 12;
	localparam int LEN_W      = 5;
	localparam int TDATA_W    = 80;
	localparam int CTR_W      = 2;
	localparam int PHT_W      = CTR_W + 1;

	// history length after reset
	localparam logic [LEN_W-1:0] HIST_LEN_RESET = 5'd21;

	// action codes
	localparam logic ACT_PREDICT = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	// counter value on first allocation
	localparam logic [CTR_W-1:0] CTR_ALLOC = 2'd2;

	// saturating 2-bit counter step (taken jumps from weak not-taken to strong taken)
	function automatic logic [CTR_W-1:0] next_counter(input logic [CTR_W-1:0] c,
		input logic taken);
		logic [CTR_W-1:0] n;
		n = 2'd0;
		if (taken) begin
			case (c)
				2'd0:    n = 2'd1;
				default: n = 2'd3;
			endcase
		end else begin
			case (c)
				2'd3:    n = 2'd2;
				default: n = 2'd0;
			endcase
		end
		return n;
	endfunction

endpackage

// ===== hdl/gshare_branch_predictor.sv =====
// ---------------------------------------------------------------------------
// gshare_branch_predictor
// path from input accept to result word: table read register, then output register
// throughput: one word per cycle while the result word is not stalled
// back-to-back items on one entry are served by forwarding the last write
// reset: a sweep over 2**max(counter, target index bits) entries (4096 by default)
// clears the tables; no input is accepted meanwhile, config writes still are
// ---------------------------------------------------------------------------
`include "gshare_branch_predictor_defines.svh"

module gshare_branch_predictor #(
	parameter int COUNTER_INDEX_BITS = gbp_pkg::COUNTER_INDEX_BITS_DEF,
	parameter int TARGET_INDEX_BITS  = gbp_pkg::TARGET_INDEX_BITS_DEF,
	parameter int HISTORY_BITS       = gbp_pkg::HISTORY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config: history_length
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gbp_pkg::LEN_W-1:0]   cfg_data,
	// input word
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// branch_pc, actual_taken, taken_target, was_predicted_taken, used_index
	input  logic [gbp_pkg::TDATA_W-1:0] s_axis_tdata,
	// action
	input  logic                        s_axis_tuser,
	// result word
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// predict_taken, next_fetch_pc, counter_index, mispredicted, redirect_pc
	output logic [gbp_pkg::TDATA_W-1:0] m_axis_tdata
);

	localparam int CIB    = COUNTER_INDEX_BITS;
	localparam int TIB    = TARGET_INDEX_BITS;
	localparam int HB     = HISTORY_BITS;
	localparam int PC_W   = gbp_pkg::PC_W;
	localparam int BTA_W  = PC_W - 2;
	localparam int TAG_W  = PC_W - 2 - TIB;
	localparam int BTB_W  = 1 + TAG_W + BTA_W;
	localparam int PHT_W  = gbp_pkg::PHT_W;
	localparam int CTR_W  = gbp_pkg::CTR_W;
	localparam int IFW    = gbp_pkg::IDX_FIELD_W;
	localparam int CLR_W  = (CIB > TIB) ? CIB : TIB;

	// input fields
	logic              in_action;
	logic [PC_W-1:0]   in_pc;
	logic              in_actual;
	logic [PC_W-1:0]   in_target;
	logic              in_pred;
	logic [IFW-1:0]    in_used;

	assign in_action = s_axis_tuser;
	assign in_pc     = s_axis_tdata[31:0];
	assign in_actual = s_axis_tdata[32];
	assign in_target = s_axis_tdata[64:33];
	assign in_pred   = s_axis_tdata[65];
	assign in_used   = s_axis_tdata[77:66];

	// control
	logic                      accept;
	logic                      adv;
	logic                      clr_busy;
	logic [CLR_W-1:0]          clr_addr;
	logic [gbp_pkg::LEN_W-1:0] hist_len_q;
	logic [HB-1:0]             hist_q;
	logic                      out_valid_q;
	logic [gbp_pkg::TDATA_W-1:0] out_data_q;

	// stage 1 item
	logic              valid_s1;
	logic              action_s1;
	logic [PC_W-1:0]   pc_s1;
	logic              actual_s1;
	logic [PC_W-1:0]   target_s1;
	logic              pred_s1;
	logic [CIB-1:0]    cidx_s1;

	// last write, for an item that read in the same cycle
	logic              fwd_pht_q;
	logic              fwd_btb_q;
	logic [CIB-1:0]    fwd_pht_addr_q;
	logic [PHT_W-1:0]  fwd_pht_data_q;
	logic [TIB-1:0]    fwd_btb_addr_q;
	logic [BTB_W-1:0]  fwd_btb_data_q;

	// memory ports
	logic              pht_we;
	logic [CIB-1:0]    pht_waddr;
	logic [PHT_W-1:0]  pht_wdata;
	logic [CIB-1:0]    pht_raddr;
	logic [PHT_W-1:0]  pht_rdata;
	logic              btb_we;
	logic [TIB-1:0]    btb_waddr;
	logic [BTB_W-1:0]  btb_wdata;
	logic [BTB_W-1:0]  btb_rdata;

	// stage 1 results
	logic              upd_pht;
	logic              upd_btb;
	logic [PHT_W-1:0]  upd_pht_data;
	logic [BTB_W-1:0]  upd_btb_data;
	logic [gbp_pkg::TDATA_W-1:0] out_data_d;

	// index forming
	logic [HB-1:0]     hist_fwd;
	logic [HB-1:0]     hmask;
	logic [31:0]       len_sat;
	logic [CIB-1:0]    pred_idx;

	// handshakes
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !clr_busy && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// table clear sweep
	gbp_clear #(
		.ADDR_W(CLR_W)
	) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (clr_busy),
		.addr  (clr_addr)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= gbp_pkg::HIST_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hist_len_q <= cfg_data;
		end
	end

	// counter index from pc and history, with history of an update in flight
	always_comb begin
		if (valid_s1 && action_s1 == gbp_pkg::ACT_RESOLVE) begin
			hist_fwd = HB'({hist_q, actual_s1});
		end else begin
			hist_fwd = hist_q;
		end
		if (32'(hist_len_q) > 32'(HB)) begin
			len_sat = 32'(HB);
		end else begin
			len_sat = 32'(hist_len_q);
		end
		for (int i = 0; i < HB; i++) begin
			hmask[i] = (32'(i) < len_sat);
		end
		pred_idx = CIB'(32'(hist_fwd & hmask) ^ {2'b00, in_pc[31:2]});
	end

	assign pht_raddr = (in_action == gbp_pkg::ACT_PREDICT) ? pred_idx : CIB'(in_used);

	// pattern history table: {valid, counter}
	gbp_ram #(
		.ADDR_W(CIB),
		.DATA_W(PHT_W)
	) u_pht (
		.clk  (clk),
		.we   (pht_we),
		.waddr(pht_waddr),
		.wdata(pht_wdata),
		.re   (accept),
		.raddr(pht_raddr),
		.rdata(pht_rdata)
	);

	// branch target buffer: {valid, tag, target word address}
	gbp_ram #(
		.ADDR_W(TIB),
		.DATA_W(BTB_W)
	) u_btb (
		.clk  (clk),
		.we   (btb_we),
		.waddr(btb_waddr),
		.wdata(btb_wdata),
		.re   (accept),
		.raddr(in_pc[TIB+1:2]),
		.rdata(btb_rdata)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= in_action;
			pc_s1     <= in_pc;
			actual_s1 <= in_actual;
			target_s1 <= in_target;
			pred_s1   <= in_pred;
			cidx_s1   <= pht_raddr;
		end
	end

	// lookup, prediction and update in stage 1
	always_comb begin
		logic [PHT_W-1:0] pht_ent;
		logic [BTB_W-1:0] btb_ent;
		logic             hit;
		logic [CTR_W-1:0] ctr_base;
		logic             taken;
		logic             mis;
		logic [PC_W-1:0]  pc_inc;

		taken = 1'b0;
		mis   = 1'b0;

		if (fwd_pht_q && fwd_pht_addr_q == cidx_s1) begin
			pht_ent = fwd_pht_data_q;
		end else begin
			pht_ent = pht_rdata;
		end
		if (fwd_btb_q && fwd_btb_addr_q == pc_s1[TIB+1:2]) begin
			btb_ent = fwd_btb_data_q;
		end else begin
			btb_ent = btb_rdata;
		end

		hit    = btb_ent[BTB_W-1] && (btb_ent[BTB_W-2:BTA_W] == pc_s1[PC_W-1:TIB+2]);
		pc_inc = pc_s1 + 32'd4;

		// allocate a missing counter at weakly taken before stepping it
		ctr_base     = pht_ent[PHT_W-1] ? pht_ent[CTR_W-1:0] : gbp_pkg::CTR_ALLOC;
		upd_pht_data = {1'b1, gbp_pkg::next_counter(ctr_base, actual_s1)};
		upd_btb_data = {1'b1, pc_s1[PC_W-1:TIB+2], target_s1[PC_W-1:2]};

		upd_pht = adv && action_s1 == gbp_pkg::ACT_RESOLVE;
		upd_btb = upd_pht && !hit;

		out_data_d = '0;
		if (action_s1 == gbp_pkg::ACT_PREDICT) begin
			taken             = hit && pht_ent[PHT_W-1] && pht_ent[CTR_W-1];
			out_data_d[0]     = taken;
			out_data_d[32:1]  = taken ? {btb_ent[BTA_W-1:0], 2'b00} : pc_inc;
			out_data_d[44:33] = IFW'(cidx_s1);
		end else begin
			mis               = actual_s1 != pred_s1;
			out_data_d[45]    = mis;
			if (mis) begin
				out_data_d[77:46] = pred_s1 ? pc_inc : target_s1;
			end
		end
	end

	// memory write ports, shared with the clear sweep
	always_comb begin
		if (clr_busy) begin
			pht_we    = 1'b1;
			pht_waddr = clr_addr[CIB-1:0];
			pht_wdata = '0;
			btb_we    = 1'b1;
			btb_waddr = clr_addr[TIB-1:0];
			btb_wdata = '0;
		end else begin
			pht_we    = upd_pht;
			pht_waddr = cidx_s1;
			pht_wdata = upd_pht_data;
			btb_we    = upd_btb;
			btb_waddr = pc_s1[TIB+1:2];
			btb_wdata = upd_btb_data;
		end
	end

	// forward flags: live only for the item that read alongside a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_pht_q <= 1'b0;
			fwd_btb_q <= 1'b0;
		end else if (accept || adv) begin
			fwd_pht_q <= accept && upd_pht;
			fwd_btb_q <= accept && upd_btb;
		end
	end

	// forward payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_pht_addr_q <= cidx_s1;
			fwd_pht_data_q <= upd_pht_data;
			fwd_btb_addr_q <= pc_s1[TIB+1:2];
			fwd_btb_data_q <= upd_btb_data;
		end
	end

	// global history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (upd_pht) begin
			hist_q <= HB'({hist_q, actual_s1});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= out_data_d;
		end
	end

	// checks
	`GBP_ASSERT_ALWAYS(a_no_accept_in_clear, clr_busy |-> !s_axis_tready, "input taken during clear sweep")
	`GBP_ASSERT(a_fwd_needs_item, (fwd_pht_q || fwd_btb_q) |-> valid_s1, "forward entry without item in stage 1")
	`GBP_ASSERT(a_btb_fwd_on_resolve, fwd_btb_q |-> fwd_pht_q, "target buffer forward without counter forward")
	`GBP_ASSERT(a_hist_shift, upd_pht |=> hist_q[0] == $past(actual_s1), "history did not take resolved outcome")
	`GBP_ASSERT(a_out_from_s1, $rose(m_axis_tvalid) |-> $past(valid_s1), "result word without item in stage 1")

endmodule

// ===== hdl/gbp_ram.sv =====
// ---------------------------------------------------------------------------
// gbp_ram
// simple dual-port synchronous ram, read-first, registered read
// ---------------------------------------------------------------------------
module gbp_ram #(
	parameter int ADDR_W = gbp_pkg::COUNTER_INDEX_BITS_DEF,
	parameter int DATA_W = gbp_pkg::PHT_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/gbp_clear.sv =====
// ---------------------------------------------------------------------------
// gbp_clear
// post-reset sweep that walks every table entry once to clear its valid bit
// ---------------------------------------------------------------------------
module gbp_clear #(
	parameter int ADDR_W = gbp_pkg::COUNTER_INDEX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              busy,
	output logic [ADDR_W-1:0] addr
);

	logic              busy_q;
	logic [ADDR_W-1:0] addr_q;

	// sweep counter, stops after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + 1'b1;
			if (addr_q == {ADDR_W{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule
